@@ hw/rtl/blpg_pkg.sv @@
// Shared types and constants of the line pixel generator.
`default_nettype none

package blpg_pkg;

    localparam int COLOR_BITS = 32;

    // Queue word: load flag, steep, minor_up, four coordinates/spans,
    // doubled minor span and the colour.
    function automatic int entry_bits(input int coord_bits);
        return 5 * coord_bits + 4 + COLOR_BITS;
    endfunction

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage : blpg_pkg

`default_nettype wire

@@ hw/rtl/blpg_front.sv @@
// Front part: takes input words, sets up loads and pushes commands to the queue.
`default_nettype none

module blpg_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                       i_valid,
    output logic                                            o_stall,
    input  wire logic                                       i_mode,
    input  wire logic [COORD_BITS-1:0]                      i_start_x,
    input  wire logic [COORD_BITS-1:0]                      i_start_y,
    input  wire logic [COORD_BITS-1:0]                      i_end_x,
    input  wire logic [COORD_BITS-1:0]                      i_end_y,
    input  wire logic [blpg_pkg::COLOR_BITS-1:0]            i_color,
    input  wire blpg_pkg::t_q_stat                          i_q_stat,
    output logic                                            o_push,
    output logic [blpg_pkg::entry_bits(COORD_BITS)-1:0]     o_entry
);
    import blpg_pkg::*;

    logic                  gt_x, gt_y, lt_x, lt_y, steep, swap, minor_up;
    logic [COORD_BITS-1:0] adx, ady, a0, a1, b0, b1;
    logic [COORD_BITS-1:0] major_pos, major_end, minor_pos, major_span, minor_span;

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid & ~i_q_stat.full;

    always_comb begin
        gt_x = i_start_x > i_end_x;
        lt_x = i_end_x > i_start_x;
        gt_y = i_start_y > i_end_y;
        lt_y = i_end_y > i_start_y;
        adx  = gt_x ? i_start_x - i_end_x : i_end_x - i_start_x;
        ady  = gt_y ? i_start_y - i_end_y : i_end_y - i_start_y;
        // ties in extent are not steep
        steep = adx < ady;
        a0 = steep ? i_start_y : i_start_x;
        a1 = steep ? i_end_y   : i_end_x;
        b0 = steep ? i_start_x : i_start_y;
        b1 = steep ? i_end_x   : i_end_y;
        // walk from the lower major coordinate
        swap       = steep ? gt_y : gt_x;
        major_pos  = swap ? a1 : a0;
        major_end  = swap ? a0 : a1;
        minor_pos  = swap ? b1 : b0;
        minor_up   = swap ? (steep ? gt_x : gt_y) : (steep ? lt_x : lt_y);
        major_span = steep ? ady : adx;
        minor_span = steep ? adx : ady;
    end

    assign o_entry = {i_mode, steep, minor_up, major_pos, major_end, minor_pos,
                      major_span, minor_span, 1'b0, i_color};

endmodule : blpg_front

`default_nettype wire

@@ hw/rtl/blpg_queue.sv @@
// Two-entry command queue between the front and back parts.
`default_nettype none

module blpg_queue #(
    parameter int WIDTH = 96
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [WIDTH-1:0]   i_data,
    input  wire logic               i_pop,
    output logic [WIDTH-1:0]        o_data,
    output blpg_pkg::t_q_stat       o_stat
);
    import blpg_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = r_count != 2'd0;
    assign o_stat.full      = r_count[1];

endmodule : blpg_queue

`default_nettype wire

@@ hw/rtl/blpg_back.sv @@
// Back part: line walker with its error accumulator and the output register.
`default_nettype none

module blpg_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire blpg_pkg::t_q_stat                          i_q_stat,
    input  wire logic [blpg_pkg::entry_bits(COORD_BITS)-1:0] i_entry,
    output logic                                            o_pop,
    output logic                                            o_valid,
    input  wire logic                                       i_stall,
    output logic                                            o_valid_res,
    output logic [COORD_BITS-1:0]                           o_pixel_x,
    output logic [COORD_BITS-1:0]                           o_pixel_y,
    output logic [blpg_pkg::COLOR_BITS-1:0]                 o_pixel_color,
    output logic                                            o_last
);
    import blpg_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int EB = C + 3;

    // unpacked queue word
    logic                  e_load, e_steep, e_up;
    logic [C-1:0]          e_mpos, e_mend, e_npos, e_span, e_nspan;
    logic                  e_pad;
    logic [COLOR_BITS-1:0] e_color;

    logic                  r_busy, n_busy;
    logic                  r_steep, n_steep;
    logic                  r_up, n_up;
    logic [C-1:0]          r_mpos, n_mpos;
    logic [C-1:0]          r_mend, n_mend;
    logic [C-1:0]          r_npos, n_npos;
    logic [C-1:0]          r_span, n_span;
    logic [C:0]            r_nspan2, n_nspan2;
    logic signed [EB-1:0]  r_err, n_err;
    logic [COLOR_BITS-1:0] r_color, n_color;

    logic                  r_ovalid;
    logic                  r_ovres, n_ovres;
    logic [C-1:0]          r_px, n_px;
    logic [C-1:0]          r_py, n_py;
    logic [COLOR_BITS-1:0] r_pcol, n_pcol;
    logic                  r_plast, n_plast;

    logic                  active, fin, over;
    logic signed [EB-1:0]  err_src, err_sum;

    assign {e_load, e_steep, e_up, e_mpos, e_mend, e_npos, e_span, e_nspan, e_pad,
            e_color} = i_entry;

    assign o_pop = i_q_stat.not_empty & (~r_ovalid | ~i_stall);

    always_comb begin
        // a load overwrites the walker state, then both cases emit from it
        n_steep  = e_load ? e_steep : r_steep;
        n_up     = e_load ? e_up    : r_up;
        n_mpos   = e_load ? e_mpos  : r_mpos;
        n_mend   = e_load ? e_mend  : r_mend;
        n_npos   = e_load ? e_npos  : r_npos;
        n_span   = e_load ? e_span  : r_span;
        n_nspan2 = e_load ? {e_nspan, e_pad} : r_nspan2;
        n_color  = e_load ? e_color : r_color;
        err_src  = e_load ? '0 : r_err;
        active   = e_load | r_busy;
        fin      = n_mpos == n_mend;

        n_ovres = active;
        n_px    = active ? (n_steep ? n_npos : n_mpos) : '0;
        n_py    = active ? (n_steep ? n_mpos : n_npos) : '0;
        n_pcol  = active ? n_color : '0;
        n_plast = active & fin;

        err_sum = err_src + $signed({2'b00, n_nspan2});
        over    = err_sum > $signed({3'b000, n_span});
        n_err   = over ? err_sum - $signed({2'b00, n_span, 1'b0}) : err_sum;
        n_busy  = active & ~fin;
        if (active && !fin) begin
            n_mpos = n_mpos + 1'b1;
            if (over) begin
                n_npos = n_up ? n_npos + 1'b1 : n_npos - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= n_busy;
            end
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_steep  <= n_steep;
            r_up     <= n_up;
            r_mpos   <= n_mpos;
            r_mend   <= n_mend;
            r_npos   <= n_npos;
            r_span   <= n_span;
            r_nspan2 <= n_nspan2;
            r_err    <= n_err;
            r_color  <= n_color;
            r_ovres  <= n_ovres;
            r_px     <= n_px;
            r_py     <= n_py;
            r_pcol   <= n_pcol;
            r_plast  <= n_plast;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_valid_res   = r_ovres;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcol;
    assign o_last        = r_plast;

endmodule : blpg_back

`default_nettype wire

@@ hw/rtl/bresenham_line_pixel_generator_unit.sv @@
// Top level of the Bresenham line pixel generator.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | i_valid / o_stall  | mode, start/end x and y, colour
//  output  | out       | o_valid / i_stall  | valid_res, pixel x and y, colour, last
//
// One word in and one word out per clock when neither side stalls.
// An accepted word is set up and pushed into the two-entry queue, then popped for
// one walker step into the output register; an output stall can keep it queued.
// The walker does one add, compare and subtract per pixel.
// Reset clears the queue, the walker busy flag and the output valid.
// An output stall holds the output register; input stalls only when the queue is full.
`default_nettype none

module bresenham_line_pixel_generator_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_mode,
    input  wire logic [COORD_BITS-1:0]          i_start_x,
    input  wire logic [COORD_BITS-1:0]          i_start_y,
    input  wire logic [COORD_BITS-1:0]          i_end_x,
    input  wire logic [COORD_BITS-1:0]          i_end_y,
    input  wire logic [blpg_pkg::COLOR_BITS-1:0] i_color,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_valid_res,
    output logic [COORD_BITS-1:0]               o_pixel_x,
    output logic [COORD_BITS-1:0]               o_pixel_y,
    output logic [blpg_pkg::COLOR_BITS-1:0]     o_pixel_color,
    output logic                                o_last
);
    import blpg_pkg::*;

    localparam int EW = entry_bits(COORD_BITS);

    t_q_stat         q_stat;
    logic            push, pop;
    logic [EW-1:0]   push_entry, pop_entry;

    blpg_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_mode    (i_mode),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_color   (i_color),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    blpg_queue #(.WIDTH(EW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_stat  (q_stat)
    );

    blpg_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_entry       (pop_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_valid_res   (o_valid_res),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

endmodule : bresenham_line_pixel_generator_unit

`default_nettype wire

@@ hw/rtl/blpg_checker.sv @@
// Port-level checks on the line pixel generator and their bind.
`default_nettype none

module blpg_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_stall,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic                            o_valid_res,
    input wire logic [COORD_BITS-1:0]           o_pixel_x,
    input wire logic [COORD_BITS-1:0]           o_pixel_y,
    input wire logic [blpg_pkg::COLOR_BITS-1:0] o_pixel_color,
    input wire logic                            o_last
);
    import blpg_pkg::*;

    // nothing left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or input stall set after reset");

    // an idle word carries no pixel
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |->
            (o_pixel_x == '0 && o_pixel_y == '0 && o_pixel_color == '0 && !o_last))
        else $error("idle result word has non-zero fields");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_valid_res)
        else $error("last flag on a word without a pixel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last)))
        else $error("stalled output word changed");

endmodule : blpg_checker

bind bresenham_line_pixel_generator_unit blpg_checker #(.COORD_BITS(COORD_BITS)) u_blpg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_valid_res   (o_valid_res),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color),
    .o_last        (o_last)
);

`default_nettype wire
